// File: src/ped_pkg.sv
// Package with the types, codes and command lookup of the plotter escape command decoder.
`timescale 1ns / 1ps

package ped_pkg;

  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_SKIP  = 3'd1,
    PH_PARAM = 3'd2,
    PH_FLAG  = 3'd3,
    PH_COUNT = 3'd4,
    PH_LABEL = 3'd5,
    PH_FONT  = 3'd6,
    PH_HALT  = 3'd7
  } phase_e;

  typedef enum logic [4:0] {
    EV_LABEL_START = 5'd0,
    EV_LABEL_BYTE  = 5'd1,
    EV_CLEAR       = 5'd2,
    EV_ENHANCE     = 5'd3,
    EV_FONT        = 5'd4,
    EV_PAGE        = 5'd5,
    EV_HEIGHT      = 5'd6,
    EV_INVERSE     = 5'd7,
    EV_CUT         = 5'd8,
    EV_MIRROR      = 5'd9,
    EV_PREAMBLE    = 5'd10,
    EV_RDT         = 5'd11,
    EV_SPEED       = 5'd12,
    EV_PLOTMODE    = 5'd13,
    EV_REWIND      = 5'd14,
    EV_ENABLE      = 5'd15,
    EV_DISABLE     = 5'd16,
    EV_UNKNOWN     = 5'd17
  } event_e;

  // Escape command words, high byte is the escape character.
  localparam logic [15:0] CmdLabel    = 16'h9B42;
  localparam logic [15:0] CmdClear    = 16'h9B43;
  localparam logic [15:0] CmdEnhance  = 16'h9B45;
  localparam logic [15:0] CmdFont     = 16'h9B46;
  localparam logic [15:0] CmdPage     = 16'h9B47;
  localparam logic [15:0] CmdHeight   = 16'h9B48;
  localparam logic [15:0] CmdInverse  = 16'h9B49;
  localparam logic [15:0] CmdCut      = 16'h9B4B;
  localparam logic [15:0] CmdMirror   = 16'h9B4D;
  localparam logic [15:0] CmdPreamble = 16'h9B50;
  localparam logic [15:0] CmdRdt      = 16'h9B52;
  localparam logic [15:0] CmdSpeed    = 16'h9B53;
  localparam logic [15:0] CmdPlotmode = 16'h9B54;
  localparam logic [15:0] CmdRewind   = 16'h9B57;
  localparam logic [15:0] CmdEnable   = 16'h9B3C;
  localparam logic [15:0] CmdDisable  = 16'h9B3E;

  typedef struct packed {
    phase_e      phase;
    logic        lo_next;
    logic [7:0]  high_byte;
    event_e      cmd;
    logic [15:0] remaining;
    logic [1:0]  skip;
  } state_t;

  typedef struct packed {
    logic        emit;
    event_e      ev;
    logic [15:0] value;
  } result_t;

  localparam state_t StateReset = '{
    phase:     PH_CMD,
    lo_next:   1'b0,
    high_byte: 8'h00,
    cmd:       EV_LABEL_START,
    remaining: 16'h0000,
    skip:      2'd0
  };

  function automatic event_e lookup(input logic [15:0] w);
    event_e ev;
    unique case (w)
      CmdLabel:    ev = EV_LABEL_START;
      CmdClear:    ev = EV_CLEAR;
      CmdEnhance:  ev = EV_ENHANCE;
      CmdFont:     ev = EV_FONT;
      CmdPage:     ev = EV_PAGE;
      CmdHeight:   ev = EV_HEIGHT;
      CmdInverse:  ev = EV_INVERSE;
      CmdCut:      ev = EV_CUT;
      CmdMirror:   ev = EV_MIRROR;
      CmdPreamble: ev = EV_PREAMBLE;
      CmdRdt:      ev = EV_RDT;
      CmdSpeed:    ev = EV_SPEED;
      CmdPlotmode: ev = EV_PLOTMODE;
      CmdRewind:   ev = EV_REWIND;
      CmdEnable:   ev = EV_ENABLE;
      CmdDisable:  ev = EV_DISABLE;
      default:     ev = EV_UNKNOWN;
    endcase
    return ev;
  endfunction

endpackage

// File: src/ped_step.sv
// Next-state and result logic of the decoder for one payload byte.
`timescale 1ns / 1ps

module ped_step (
  input  ped_pkg::state_t  state_i,
  input  logic [7:0]       byte_i,
  input  logic             first_i,
  input  logic             last_i,
  output ped_pkg::state_t  state_o,
  output ped_pkg::result_t result_o
);

  ped_pkg::state_t  cur;
  ped_pkg::state_t  nxt;
  ped_pkg::result_t res;
  logic [15:0]      word;
  logic [15:0]      rem_dec;
  logic [1:0]       skip_dec;
  ped_pkg::event_e  found;

  // A first mark restarts the decoder before the byte is used.
  assign cur      = first_i ? ped_pkg::StateReset : state_i;
  assign word     = {cur.high_byte, byte_i};
  assign rem_dec  = cur.remaining - 16'd1;
  assign skip_dec = cur.skip - 2'd1;
  assign found    = ped_pkg::lookup(word);

  always_comb begin
    nxt       = cur;
    res.emit  = 1'b0;
    res.ev    = ped_pkg::EV_LABEL_START;
    res.value = 16'h0000;
    unique case (cur.phase)
      ped_pkg::PH_HALT: begin
      end
      ped_pkg::PH_FLAG: begin
        nxt.phase = ped_pkg::PH_CMD;
        res.emit  = 1'b1;
        res.ev    = ped_pkg::EV_PREAMBLE;
        res.value = {8'h00, byte_i};
      end
      ped_pkg::PH_LABEL: begin
        nxt.remaining = rem_dec;
        if (rem_dec == 16'h0000) nxt.phase = ped_pkg::PH_CMD;
        res.emit  = 1'b1;
        res.ev    = ped_pkg::EV_LABEL_BYTE;
        res.value = {8'h00, byte_i};
      end
      ped_pkg::PH_FONT: begin
        nxt.remaining = rem_dec;
        if (rem_dec == 16'h0000) nxt.phase = ped_pkg::PH_CMD;
      end
      default: begin
        if (!cur.lo_next) begin
          nxt.high_byte = byte_i;
          nxt.lo_next   = 1'b1;
        end else begin
          nxt.lo_next = 1'b0;
          case (cur.phase)
            ped_pkg::PH_CMD: begin
              // Zero words between commands are padding.
              if (word != 16'h0000) begin
                nxt.cmd = found;
                if (found == ped_pkg::EV_UNKNOWN) begin
                  nxt.phase = ped_pkg::PH_HALT;
                  res.emit  = 1'b1;
                  res.ev    = ped_pkg::EV_UNKNOWN;
                end else if (found == ped_pkg::EV_LABEL_START ||
                             found == ped_pkg::EV_FONT) begin
                  nxt.phase = ped_pkg::PH_COUNT;
                end else if (found == ped_pkg::EV_PREAMBLE) begin
                  nxt.skip  = 2'd2;
                  nxt.phase = ped_pkg::PH_SKIP;
                end else begin
                  nxt.skip  = 2'd1;
                  nxt.phase = ped_pkg::PH_SKIP;
                end
              end
            end
            ped_pkg::PH_SKIP: begin
              nxt.skip = skip_dec;
              if (skip_dec == 2'd0) begin
                if (cur.cmd == ped_pkg::EV_PREAMBLE) begin
                  nxt.phase = ped_pkg::PH_FLAG;
                end else if (cur.cmd == ped_pkg::EV_HEIGHT || cur.cmd == ped_pkg::EV_RDT ||
                             cur.cmd == ped_pkg::EV_SPEED ||
                             cur.cmd == ped_pkg::EV_PLOTMODE) begin
                  nxt.phase = ped_pkg::PH_PARAM;
                end else begin
                  nxt.phase = ped_pkg::PH_CMD;
                  res.emit  = 1'b1;
                  res.ev    = cur.cmd;
                end
              end
            end
            ped_pkg::PH_PARAM: begin
              nxt.phase = ped_pkg::PH_CMD;
              res.emit  = 1'b1;
              res.ev    = cur.cmd;
              res.value = word;
            end
            ped_pkg::PH_COUNT: begin
              nxt.remaining = word;
              if (word == 16'h0000) begin
                nxt.phase = ped_pkg::PH_CMD;
              end else if (cur.cmd == ped_pkg::EV_FONT) begin
                nxt.phase = ped_pkg::PH_FONT;
              end else begin
                nxt.phase = ped_pkg::PH_LABEL;
              end
              res.emit  = 1'b1;
              res.ev    = cur.cmd;
              res.value = word;
            end
            default: begin
            end
          endcase
        end
      end
    endcase
    // The record ends here: anything unfinished is dropped.
    if (last_i) nxt = ped_pkg::StateReset;
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

// File: src/plotter_escape_command_decoder.sv
// Top level of the plotter escape command decoder: state and result registers.
`timescale 1ns / 1ps

// Takes one payload byte per cycle while s_axis_tready is high and gives at most one
// event per byte, in the cycle after the byte is taken. Every byte is decoded
// combinationally against the decoder state register, so a new byte is taken in
// every cycle in which the result register is empty or its event is being taken
// at the same edge. tuser marks the first byte of a record and tlast the last one.

module plotter_escape_command_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] first_of_record
  input  logic        s_axis_tlast,   // last_of_record
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [4:0] event_res, [20:5] value, [23:21] zero
);

  ped_pkg::state_t  state_q;
  ped_pkg::state_t  state_d;
  ped_pkg::result_t res;
  logic             out_valid_q;
  logic [4:0]       out_event_q;
  logic [15:0]      out_value_q;
  logic             s_fire;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  ped_step u_step (
    .state_i  (state_q),
    .byte_i   (s_axis_tdata),
    .first_i  (s_axis_tuser),
    .last_i   (s_axis_tlast),
    .state_o  (state_d),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ped_pkg::StateReset;
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      state_q     <= state_d;
      out_valid_q <= res.emit;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_event_q <= res.ev;
      out_value_q <= res.value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_value_q, out_event_q};

  // An item that closes a record leaves the decoder waiting for a fresh command word.
  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast |=> state_q.phase == ped_pkg::PH_CMD && !state_q.lo_next)
    else $error("state not cleared after last item of a record");

  // The result register holds an item exactly when the decoded item produced an event.
  a_emit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> m_axis_tvalid == $past(res.emit))
    else $error("result valid does not follow the decoded event");

  // Halting is only reached through an unknown command word.
  a_halt_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == ped_pkg::PH_HALT |-> state_q.cmd == ped_pkg::EV_UNKNOWN)
    else $error("halt without unknown command");

  // Byte-wise phases always have at least one byte left.
  a_count_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == ped_pkg::PH_LABEL || state_q.phase == ped_pkg::PH_FONT |->
      state_q.remaining != 16'h0000)
    else $error("byte-wise phase with zero count");

endmodule

// File: tb/plotter_escape_command_decoder_tb.sv
// Testbench for the plotter escape command decoder: directed table, random records, event checks.
`timescale 1ns / 1ps

module plotter_escape_command_decoder_tb;

  localparam int          DirRows    = 25;
  localparam int          RandItems  = 1700;
  localparam int          CalmItems  = 150;
  localparam int          LongHold   = 120;
  localparam int          HoldAfter  = 400;
  localparam int          StallLimit = 1000;
  localparam int          TailCycles = 4;
  localparam logic [7:0]  EscByte    = ped_pkg::CmdClear[15:8];

  typedef struct {
    logic [7:0]      data;
    logic            first;
    logic            last;
    bit              fixed;
    ped_pkg::event_e fev;
    logic [15:0]     fval;
  } byte_item_t;

  typedef struct {
    ped_pkg::event_e ev;
    logic [15:0]     value;
  } decoder_event_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  byte_item_t     byte_stream [$];
  byte_item_t     dir_tab [DirRows];
  decoder_event_t pending_events [$];
  bit             seen_ev [0:17];

  int unsigned in_count  = 0;
  int unsigned out_count = 0;
  int unsigned errors    = 0;
  int unsigned records   = 0;
  bit          calm      = 1'b0;

  // Shadow copy of the decoder state.
  ped_pkg::phase_e dec_phase;
  bit              dec_low_next;
  logic [7:0]      dec_held;
  ped_pkg::event_e dec_cmd;
  logic [15:0]     dec_left;
  logic [1:0]      dec_skip;

  plotter_escape_command_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic void note_failure(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic logic [15:0] word_of(input ped_pkg::event_e c);
    logic [15:0] w;
    case (c)
      ped_pkg::EV_LABEL_START: w = ped_pkg::CmdLabel;
      ped_pkg::EV_CLEAR:       w = ped_pkg::CmdClear;
      ped_pkg::EV_ENHANCE:     w = ped_pkg::CmdEnhance;
      ped_pkg::EV_FONT:        w = ped_pkg::CmdFont;
      ped_pkg::EV_PAGE:        w = ped_pkg::CmdPage;
      ped_pkg::EV_HEIGHT:      w = ped_pkg::CmdHeight;
      ped_pkg::EV_INVERSE:     w = ped_pkg::CmdInverse;
      ped_pkg::EV_CUT:         w = ped_pkg::CmdCut;
      ped_pkg::EV_MIRROR:      w = ped_pkg::CmdMirror;
      ped_pkg::EV_PREAMBLE:    w = ped_pkg::CmdPreamble;
      ped_pkg::EV_RDT:         w = ped_pkg::CmdRdt;
      ped_pkg::EV_SPEED:       w = ped_pkg::CmdSpeed;
      ped_pkg::EV_PLOTMODE:    w = ped_pkg::CmdPlotmode;
      ped_pkg::EV_REWIND:      w = ped_pkg::CmdRewind;
      ped_pkg::EV_ENABLE:      w = ped_pkg::CmdEnable;
      ped_pkg::EV_DISABLE:     w = ped_pkg::CmdDisable;
      default:                 w = 16'h0000;
    endcase
    return w;
  endfunction

  // Reverse search over the command words; anything not found is unknown.
  function automatic ped_pkg::event_e command_of(input logic [15:0] w);
    ped_pkg::event_e c;
    int              i;
    c = ped_pkg::EV_UNKNOWN;
    for (i = 0; i < ped_pkg::EV_UNKNOWN; i++) begin
      if (i != ped_pkg::EV_LABEL_BYTE && word_of(ped_pkg::event_e'(i)) == w) begin
        c = ped_pkg::event_e'(i);
      end
    end
    return c;
  endfunction

  function automatic void clear_decoder();
    dec_phase    = ped_pkg::PH_CMD;
    dec_low_next = 1'b0;
    dec_held     = 8'h00;
    dec_cmd      = ped_pkg::EV_LABEL_START;
    dec_left     = 16'h0000;
    dec_skip     = 2'd0;
  endfunction

  // Advances the shadow state by one byte; returns 1 when the byte yields an event.
  function automatic bit decode_byte(input logic [7:0] b, input logic first, input logic last,
                                     output ped_pkg::event_e ev, output logic [15:0] val);
    bit              hit;
    logic [15:0]     w;
    ped_pkg::event_e c;
    hit = 1'b0;
    ev  = ped_pkg::EV_LABEL_START;
    val = 16'h0000;
    if (first) clear_decoder();
    case (dec_phase)
      ped_pkg::PH_HALT: ;
      ped_pkg::PH_FLAG: begin
        dec_phase = ped_pkg::PH_CMD;
        hit = 1'b1;
        ev  = ped_pkg::EV_PREAMBLE;
        val = {8'h00, b};
      end
      ped_pkg::PH_LABEL: begin
        dec_left = dec_left - 16'd1;
        if (dec_left == 16'h0000) dec_phase = ped_pkg::PH_CMD;
        hit = 1'b1;
        ev  = ped_pkg::EV_LABEL_BYTE;
        val = {8'h00, b};
      end
      ped_pkg::PH_FONT: begin
        dec_left = dec_left - 16'd1;
        if (dec_left == 16'h0000) dec_phase = ped_pkg::PH_CMD;
      end
      default: begin
        if (!dec_low_next) begin
          dec_held     = b;
          dec_low_next = 1'b1;
        end else begin
          dec_low_next = 1'b0;
          w = {dec_held, b};
          case (dec_phase)
            ped_pkg::PH_CMD: begin
              if (w != 16'h0000) begin
                c = command_of(w);
                dec_cmd = c;
                if (c == ped_pkg::EV_UNKNOWN) begin
                  dec_phase = ped_pkg::PH_HALT;
                  hit = 1'b1;
                  ev  = ped_pkg::EV_UNKNOWN;
                end else if (c == ped_pkg::EV_LABEL_START || c == ped_pkg::EV_FONT) begin
                  dec_phase = ped_pkg::PH_COUNT;
                end else begin
                  dec_skip  = (c == ped_pkg::EV_PREAMBLE) ? 2'd2 : 2'd1;
                  dec_phase = ped_pkg::PH_SKIP;
                end
              end
            end
            ped_pkg::PH_SKIP: begin
              dec_skip = dec_skip - 2'd1;
              if (dec_skip == 2'd0) begin
                if (dec_cmd == ped_pkg::EV_PREAMBLE) begin
                  dec_phase = ped_pkg::PH_FLAG;
                end else if (dec_cmd == ped_pkg::EV_HEIGHT || dec_cmd == ped_pkg::EV_RDT ||
                             dec_cmd == ped_pkg::EV_SPEED ||
                             dec_cmd == ped_pkg::EV_PLOTMODE) begin
                  dec_phase = ped_pkg::PH_PARAM;
                end else begin
                  dec_phase = ped_pkg::PH_CMD;
                  hit = 1'b1;
                  ev  = dec_cmd;
                end
              end
            end
            ped_pkg::PH_PARAM: begin
              dec_phase = ped_pkg::PH_CMD;
              hit = 1'b1;
              ev  = dec_cmd;
              val = w;
            end
            ped_pkg::PH_COUNT: begin
              dec_left  = w;
              dec_phase = (w == 16'h0000) ? ped_pkg::PH_CMD :
                          ((dec_cmd == ped_pkg::EV_FONT) ? ped_pkg::PH_FONT :
                                                           ped_pkg::PH_LABEL);
              hit = 1'b1;
              ev  = dec_cmd;
              val = w;
            end
            default: ;
          endcase
        end
      end
    endcase
    if (last) clear_decoder();
    return hit;
  endfunction

  function automatic void take_byte(input byte_item_t it);
    decoder_event_t  e;
    ped_pkg::event_e ev;
    logic [15:0]     val;
    bit              hit;
    in_count++;
    hit = decode_byte(it.data, it.first, it.last, ev, val);
    if (it.fixed) begin
      e.ev    = it.fev;
      e.value = it.fval;
      pending_events.push_back(e);
    end else if (hit) begin
      e.ev    = ev;
      e.value = val;
      pending_events.push_back(e);
    end
  endfunction

  task automatic add_byte(input logic [7:0] b);
    byte_item_t it;
    it.data  = b;
    it.first = 1'b0;
    it.last  = 1'b0;
    it.fixed = 1'b0;
    it.fev   = ped_pkg::EV_LABEL_START;
    it.fval  = 16'h0000;
    byte_stream.push_back(it);
  endtask

  task automatic add_word(input logic [15:0] w);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
  endtask

  task automatic add_command();
    int unsigned     pick;
    int unsigned     n;
    ped_pkg::event_e c;
    logic [15:0]     w;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      do begin
        w = ($urandom_range(0, 1) == 1) ? {EscByte, 8'($urandom)} : 16'($urandom);
      end while (w == 16'h0000 || command_of(w) != ped_pkg::EV_UNKNOWN);
      add_word(w);
    end else if (pick < 12) begin
      add_word(16'h0000);
    end else begin
      do begin
        c = ped_pkg::event_e'($urandom_range(0, ped_pkg::EV_DISABLE));
      end while (c == ped_pkg::EV_LABEL_BYTE);
      add_word(word_of(c));
      case (c)
        ped_pkg::EV_LABEL_START, ped_pkg::EV_FONT: begin
          // Mostly short labels; now and then a count above one byte.
          n = ($urandom_range(0, 49) == 0) ? $urandom_range(256, 600) : $urandom_range(0, 8);
          add_word(16'(n));
          repeat (n) add_byte(8'($urandom));
        end
        ped_pkg::EV_PREAMBLE: begin
          add_word(16'($urandom));
          add_word(16'($urandom));
          add_byte(8'($urandom));
        end
        ped_pkg::EV_HEIGHT, ped_pkg::EV_RDT, ped_pkg::EV_SPEED, ped_pkg::EV_PLOTMODE: begin
          add_word(16'($urandom));
          add_word(16'($urandom));
        end
        default: add_word(16'($urandom));
      endcase
    end
  endtask

  task automatic add_record();
    int          head;
    int unsigned cut;
    head = byte_stream.size();
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) add_command();
    end
    if ($urandom_range(0, 9) == 0 && byte_stream.size() - head > 1) begin
      cut = $urandom_range(1, byte_stream.size() - head - 1);
      repeat (cut) void'(byte_stream.pop_back());
    end
    if ($urandom_range(0, 19) != 0) byte_stream[head].first = 1'b1;
    if ($urandom_range(0, 19) != 0) byte_stream[byte_stream.size() - 1].last = 1'b1;
    records++;
  endtask

  initial begin : stimulus_driver
    int unsigned idx;
    int unsigned gap;
    int unsigned kinds;
    clear_decoder();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_tab = '{
      // Clear with its dummy word.
      '{EscByte,                   1'b1, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{ped_pkg::CmdClear[7:0],    1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'h00,                     1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'h00,                     1'b0, 1'b0, 1'b1, ped_pkg::EV_CLEAR,       16'h0000},
      // Label and font load with a count of zero.
      '{EscByte,                   1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{ped_pkg::CmdLabel[7:0],    1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'h00,                     1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'h00,                     1'b0, 1'b0, 1'b1, ped_pkg::EV_LABEL_START, 16'h0000},
      '{EscByte,                   1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{ped_pkg::CmdFont[7:0],     1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'h00,                     1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'h00,                     1'b0, 1'b0, 1'b1, ped_pkg::EV_FONT,        16'h0000},
      // Unknown word, then a byte that must be ignored.
      '{8'hFF,                     1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'hFF,                     1'b0, 1'b0, 1'b1, ped_pkg::EV_UNKNOWN,     16'h0000},
      '{EscByte,                   1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      // New record: preamble skips two words and takes a flag byte.
      '{EscByte,                   1'b1, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{ped_pkg::CmdPreamble[7:0], 1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'hFF,                     1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'hFF,                     1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'h00,                     1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'h00,                     1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'hFF,                     1'b0, 1'b0, 1'b1, ped_pkg::EV_PREAMBLE,    16'h00FF},
      // Record ends right after a speed command; next byte has no first mark.
      '{EscByte,                   1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{ped_pkg::CmdSpeed[7:0],    1'b0, 1'b1, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000},
      '{8'h00,                     1'b0, 1'b0, 1'b0, ped_pkg::EV_LABEL_START, 16'h0000}
    };
    foreach (dir_tab[i]) byte_stream.push_back(dir_tab[i]);
    while (byte_stream.size() < DirRows + RandItems) add_record();

    for (idx = 0; idx < byte_stream.size(); idx++) begin
      calm = (idx + CalmItems >= byte_stream.size());
      gap = 0;
      if (!calm && (idx / 128) % 3 != 2 && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
      end
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= byte_stream[idx].data;
      s_axis_tuser  <= byte_stream[idx].first;
      s_axis_tlast  <= byte_stream[idx].last;
      do @(posedge clk_i); while (!s_axis_tready);
      take_byte(byte_stream[idx]);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    kinds = 0;
    foreach (seen_ev[i]) kinds += seen_ev[i];
    $display("Run: %0d bytes (%0d directed) in %0d random records, %0d events checked",
             in_count, DirRows, records, out_count);
    $display("Run: %0d of 18 event kinds observed, %0d failures", kinds, errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Output side: random stalls, one long hold-off so that the input side backs up.
  initial begin : event_sink
    int unsigned hold;
    bit          long_done;
    hold = 0;
    long_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_done && in_count >= HoldAfter) begin
        long_done = 1'b1;
        hold = LongHold;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!calm && (out_count / 96) % 3 != 1 && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    decoder_event_t want;
    logic [4:0]     got_ev;
    logic [15:0]    got_val;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_ev  = m_axis_tdata[4:0];
      got_val = m_axis_tdata[20:5];
      out_count++;
      if (pending_events.size() == 0) begin
        note_failure($sformatf("event %0d value %h with nothing pending", got_ev, got_val));
      end else begin
        want = pending_events.pop_front();
        if (got_ev !== want.ev || got_val !== want.value || m_axis_tdata[23:21] !== 3'b000) begin
          note_failure($sformatf("expected event %0d value %h, got event %0d value %h pad %b",
                                 want.ev, want.value, got_ev, got_val, m_axis_tdata[23:21]));
        end else begin
          seen_ev[want.ev] = 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no item moved for %0d cycles", StallLimit);
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: plotter_escape_command_decoder.f
src/ped_pkg.sv
src/ped_step.sv
src/plotter_escape_command_decoder.sv
tb/plotter_escape_command_decoder_tb.sv
